@@ rtl/b64_pkg.sv @@
// Shared types, constants and alphabet functions for the Base64 codec.
// No dependencies; every other file of the codec imports this package.
package b64_pkg;

    // Largest number of results that one input byte can cause.
    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // Mode register codes.
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // One accepted input request.
    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } item_t;

    // One result request on the output channel.
    typedef struct packed {
        logic       bad_char;
        logic       end_of_message;
        logic       has_data;
        logic [7:0] out_byte;
    } result_t;

    // All results that one input request causes, in delivery order from entry 0.
    typedef struct packed {
        logic [RES_CNT_W-1:0]              count;
        result_t [MAX_RESULTS-1:0]         res;
    } group_t;

    // Maps a six-bit value to its character of the standard alphabet.
    function automatic logic [7:0] enc_char(input logic [5:0] sextet);
        logic [7:0] wide;
        wide = {2'b00, sextet};
        if (sextet < 6'd26) begin
            return 8'(wide + 8'h41);
        end else if (sextet < 6'd52) begin
            return 8'(wide + 8'h47);
        end else if (sextet < 6'd62) begin
            return 8'(wide - 8'd4);
        end else if (sextet == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

    // Maps a character to {valid, six-bit value}; valid is low outside the alphabet.
    function automatic logic [6:0] dec_lookup(input logic [7:0] c);
        if (c inside {[8'h41:8'h5A]}) begin
            return {1'b1, 6'(c - 8'h41)};
        end else if (c inside {[8'h61:8'h7A]}) begin
            return {1'b1, 6'(c - 8'h47)};
        end else if (c inside {[8'h30:8'h39]}) begin
            return {1'b1, 6'(c + 8'd4)};
        end else if (c == 8'h2B) begin
            return {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            return {1'b1, 6'd63};
        end else begin
            return 7'd0;
        end
    endfunction

endpackage

@@ rtl/b64_in_reg.sv @@
// Input register stage of the Base64 codec: holds one request for the core.
// Depends on b64_pkg for the request type.
module b64_in_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tlast,
    input  logic          take,
    output logic          item_valid,
    output b64_pkg::item_t item
);
    import b64_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // The stage can load whenever it is empty or its request moves on this cycle.
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.data <= s_tdata;
            item_reg.last <= s_tlast;
        end
    end

endmodule

@@ rtl/b64_core.sv @@
// Codec core: mode register, bit accumulator state and the per-request result logic.
// Depends on b64_pkg for types and alphabet functions.
module b64_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic           cfg_wr_data,
    input  b64_pkg::item_t item,
    input  logic           take,
    output b64_pkg::group_t group
);
    import b64_pkg::*;

    logic       mode_reg;
    // Pending bits never exceed six in either mode.
    logic [5:0] store_reg, store_next;
    logic [2:0] count_reg, count_next;
    logic       drop_reg, drop_next;

    // Encode path signals.
    logic [11:0] enc_acc;
    logic [3:0]  enc_tot;
    logic [3:0]  enc_rem;
    logic [1:0]  enc_nchar;
    logic [5:0]  enc_ch0, enc_ch1, enc_left, enc_tail;
    logic [1:0]  enc_pads;
    logic [2:0]  enc_n;
    logic        enc_has_tail;

    // Decode path signals.
    logic        dec_skip;
    logic [6:0]  dec_look;
    logic [11:0] dec_acc;
    logic [3:0]  dec_tot;
    logic [3:0]  dec_rem;
    logic        dec_emit;
    logic [7:0]  dec_byte;
    logic [5:0]  dec_left;

    logic [2:0]  slot;
    group_t      grp;

    // Encode: append eight bits, then cut off complete sextets and the padded tail.
    always_comb begin
        enc_acc   = {store_reg[3:0], item.data};
        enc_tot   = {1'b0, count_reg} + 4'd8;
        enc_nchar = (enc_tot >= 4'd12) ? 2'd2 : 2'd1;
        enc_rem   = enc_tot - ((enc_nchar == 2'd2) ? 4'd12 : 4'd6);
        enc_ch0   = 6'(enc_acc >> (enc_tot - 4'd6));
        enc_ch1   = 6'(enc_acc >> (enc_tot - 4'd12));
        enc_left  = 6'(enc_acc & ((12'd1 << enc_rem) - 12'd1));
        enc_tail  = enc_left << (4'd6 - enc_rem);
        enc_pads  = (enc_rem == 4'd2) ? 2'd2 : 2'd1;
        enc_has_tail = item.last && (enc_rem != 4'd0);
        enc_n = {1'b0, enc_nchar} + (enc_has_tail ? (3'd1 + {1'b0, enc_pads}) : 3'd0);
        if (enc_n > 3'(MAX_RESULTS)) begin
            enc_n = 3'(MAX_RESULTS);
        end
    end

    // Decode: skip whitespace and padding, append six bits, emit a full byte.
    always_comb begin
        dec_skip = (item.data == SPACE_CHAR) || (item.data inside {[8'd9:8'd13]}) ||
                   (item.data == PAD_CHAR);
        dec_look = dec_lookup(item.data);
        dec_acc  = {store_reg, dec_look[5:0]};
        dec_tot  = {1'b0, count_reg} + 4'd6;
        dec_emit = (dec_tot >= 4'd8);
        dec_rem  = dec_emit ? (dec_tot - 4'd8) : dec_tot;
        dec_byte = 8'(dec_acc >> dec_rem);
        dec_left = 6'(dec_acc & ((12'd1 << dec_rem) - 12'd1));
    end

    // Result group and next state for the request in the input register.
    always_comb begin
        grp        = '0;
        store_next = store_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        slot       = '0;

        if (drop_reg) begin
            // Rest of an aborted message: nothing comes out.
            if (item.last) begin
                store_next = '0;
                count_next = '0;
                drop_next  = 1'b0;
            end
        end else if (mode_reg == MODE_ENCODE) begin
            grp.count = enc_n;
            for (int k = 0; k < MAX_RESULTS; k++) begin
                slot = 3'(k);
                if (slot < enc_n) begin
                    grp.res[k].has_data = 1'b1;
                    if (slot == 3'd0) begin
                        grp.res[k].out_byte = enc_char(enc_ch0);
                    end else if (slot < {1'b0, enc_nchar}) begin
                        grp.res[k].out_byte = enc_char(enc_ch1);
                    end else if (slot == {1'b0, enc_nchar}) begin
                        grp.res[k].out_byte = enc_char(enc_tail);
                    end else begin
                        grp.res[k].out_byte = PAD_CHAR;
                    end
                    grp.res[k].end_of_message = item.last && (slot == enc_n - 3'd1);
                end
            end
            if (item.last) begin
                store_next = '0;
                count_next = '0;
            end else begin
                store_next = enc_left;
                count_next = enc_rem[2:0];
            end
        end else begin
            if (!dec_skip && !dec_look[6]) begin
                // Character outside the alphabet ends the message with an error.
                grp.count                 = 3'd1;
                grp.res[0].end_of_message = 1'b1;
                grp.res[0].bad_char       = 1'b1;
                store_next = '0;
                count_next = '0;
                drop_next  = !item.last;
            end else begin
                if (!dec_skip) begin
                    store_next = dec_left;
                    count_next = dec_rem[2:0];
                    if (dec_emit) begin
                        grp.count           = 3'd1;
                        grp.res[0].has_data = 1'b1;
                        grp.res[0].out_byte = dec_byte;
                    end
                end
                if (item.last) begin
                    // Leftover bits are dropped; a quiet end still gets one result.
                    grp.count                 = 3'd1;
                    grp.res[0].end_of_message = 1'b1;
                    store_next = '0;
                    count_next = '0;
                end
            end
        end
    end

    assign group = grp;

    // Mode write abandons any message in progress.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_ENCODE;
            store_reg <= '0;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            mode_reg  <= cfg_wr_data;
            store_reg <= '0;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end else if (take) begin
            store_reg <= store_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

endmodule

@@ rtl/b64_out_queue.sv @@
// Base64 result register: holds one request's results, sends one per cycle when m_tready.
// Depends on b64_pkg for the result and group types.
module b64_out_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  b64_pkg::group_t group,
    output logic            free,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast,
    output logic [1:0]      m_tuser
);
    import b64_pkg::*;

    logic [RES_CNT_W-1:0]      rem_reg;
    result_t [MAX_RESULTS-1:0] ent_reg;
    logic                      pop;

    assign pop      = (rem_reg != '0) && m_tready;
    // A new group may enter once the last waiting result leaves.
    assign free     = (rem_reg == '0) || ((rem_reg == RES_CNT_W'(1)) && m_tready);
    assign m_tvalid = (rem_reg != '0);
    assign m_tdata  = ent_reg[0].out_byte;
    assign m_tlast  = ent_reg[0].end_of_message;
    assign m_tuser  = {ent_reg[0].bad_char, ent_reg[0].has_data};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else if (load) begin
            rem_reg <= group.count;
        end else if (pop) begin
            rem_reg <= rem_reg - RES_CNT_W'(1);
        end
    end

    // Results shift toward entry 0 as each one is taken.
    always_ff @(posedge aclk) begin
        if (load) begin
            ent_reg <= group.res;
        end else if (pop) begin
            for (int k = 0; k < MAX_RESULTS - 1; k++) begin
                ent_reg[k] <= ent_reg[k+1];
            end
        end
    end

endmodule

@@ rtl/base64_codec.sv @@
// Top level of the streaming Base64 codec (standard alphabet, padded encode).
// Depends on b64_pkg, b64_in_reg, b64_core and b64_out_queue.
//
// Streaming Base64 codec. With mode 0 each input byte becomes one or two alphabet
// characters, and the last byte of a message adds any zero-filled tail character and
// '=' padding, up to four characters in all. With mode 1 each character adds six bits
// and a byte comes out once eight are gathered; whitespace and '=' are skipped, and a
// character outside the alphabet gives one result with bad_char set that ends the
// message, after which input up to the message's last byte is dropped. A decode
// message whose last character makes no byte ends with a result that has has_data low.
// Writing mode abandons any message in progress; write it only while the codec is idle.
// Timing: an accepted request waits in the input register and moves into the result
// register once that register is free; its results are then taken from that register.
// The result register sends one result per cycle while m_tready is high, so a
// request holds the input side until its results have gone (1 or 2 while encoding,
// up to 4 at the end of a message; at most 1 while decoding), and requests with no
// result pass at one per cycle while the result register is empty.
module base64_codec (
    input  logic       aclk,
    input  logic       aresetn,
    // Mode register write.
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    // Input stream.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    // Result stream.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // end_of_message
    output logic [1:0] m_tuser    // [0] has_data, [1] bad_char
);
    import b64_pkg::*;

    item_t  item;
    logic   item_valid;
    logic   take;
    logic   free;
    group_t group;

    // A held request moves into the result register when that register frees up.
    assign take = item_valid && free;

    b64_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    b64_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .take        (take),
        .group       (group)
    );

    b64_out_queue u_out_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take),
        .group    (group),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

@@ test/base64_codec_test.sv @@
// Self-checking testbench for base64_codec: directed and random encode/decode traffic.
// Depends on b64_pkg and the codec RTL. Every output request is predicted and checked in order.
module base64_codec_test;
    import b64_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 40;
    localparam int ITEMS_PER_MODE = 65;

    // Whitespace characters that decode skips, besides SPACE_CHAR.
    localparam logic [7:0] TAB_CHAR = 8'h09;
    localparam logic [7:0] LF_CHAR  = 8'h0A;
    localparam logic [7:0] VT_CHAR  = 8'h0B;
    localparam logic [7:0] FF_CHAR  = 8'h0C;
    localparam logic [7:0] CR_CHAR  = 8'h0D;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] data_byte
    logic       s_tlast;    // last_byte
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] out_byte
    logic       m_tlast;    // end_of_message
    logic [1:0] m_tuser;    // [0] has_data, [1] bad_char

    // Predictor state: a private copy of the mode and the message accumulator.
    logic        codec_mode;
    logic [11:0] bit_acc;
    logic [2:0]  bit_cnt;
    logic        dropping_rest;
    result_t     awaited_outputs[$];

    int send_idle_pct;
    int recv_idle_pct;
    int useful_items;
    int fail_count;
    int cycle_count;
    result_t seen_output;
    result_t wanted_output;

    base64_codec dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    always #4 aclk = ~aclk;

    // Maps a six-bit group to its character of the standard alphabet.
    function automatic logic [7:0] char_of_sextet(input logic [5:0] s);
        if (s < 6'd26) begin
            return 8'("A" + s);
        end else if (s < 6'd52) begin
            return 8'("a" + (s - 6'd26));
        end else if (s < 6'd62) begin
            return 8'("0" + (s - 6'd52));
        end else if (s == 6'd62) begin
            return "+";
        end
        return "/";
    endfunction

    // Returns {valid, value}; valid is low for characters outside the alphabet.
    function automatic logic [6:0] sextet_of_char(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return {1'b1, 6'(c - "A")};
        end else if (c >= "a" && c <= "z") begin
            return {1'b1, 6'(c - "a" + 26)};
        end else if (c >= "0" && c <= "9") begin
            return {1'b1, 6'(c - "0" + 52)};
        end else if (c == "+") begin
            return {1'b1, 6'd62};
        end else if (c == "/") begin
            return {1'b1, 6'd63};
        end
        return 7'd0;
    endfunction

    function automatic logic is_skipped(input logic [7:0] c);
        return c == SPACE_CHAR || (c >= TAB_CHAR && c <= CR_CHAR) || c == PAD_CHAR;
    endfunction

    function automatic result_t data_result(input logic [7:0] b);
        result_t r;
        r = '0;
        r.out_byte = b;
        r.has_data = 1'b1;
        return r;
    endfunction

    function automatic logic [7:0] random_blank();
        int k;
        k = $urandom_range(0, 5);
        if (k == 5) begin
            return SPACE_CHAR;
        end
        return 8'(TAB_CHAR + k);
    endfunction

    // Works out the output requests caused by one accepted input request.
    task automatic codec_step(input logic [7:0] c, input logic last);
        result_t     outs [MAX_RESULTS];
        int          n;
        int          cnt;
        logic [11:0] acc;
        logic [6:0]  lookup;
        result_t     bad;
        n = 0;
        if (dropping_rest) begin
            if (last) begin
                dropping_rest = 1'b0;
            end
            return;
        end
        useful_items++;
        if (codec_mode == MODE_ENCODE) begin
            // Eight new bits; every full group of six becomes a character.
            acc = {bit_acc[3:0], c};
            cnt = int'(bit_cnt) + 8;
            while (cnt >= 6) begin
                cnt -= 6;
                outs[n] = data_result(char_of_sextet(6'(acc >> cnt)));
                n++;
            end
            acc = acc & ((12'd1 << cnt) - 12'd1);
            if (last) begin
                // Zero-filled tail character, then padding to a multiple of four.
                if (cnt > 0) begin
                    outs[n] = data_result(char_of_sextet(6'(acc << (6 - cnt))));
                    n++;
                    outs[n] = data_result(PAD_CHAR);
                    n++;
                    if (cnt == 2) begin
                        outs[n] = data_result(PAD_CHAR);
                        n++;
                    end
                end
            end else begin
                bit_acc = acc;
                bit_cnt = 3'(cnt);
            end
        end else if (!is_skipped(c)) begin
            lookup = sextet_of_char(c);
            if (!lookup[6]) begin
                // A character outside the alphabet ends the message with an error.
                bad = '0;
                bad.end_of_message = 1'b1;
                bad.bad_char = 1'b1;
                awaited_outputs.push_back(bad);
                bit_acc = '0;
                bit_cnt = '0;
                dropping_rest = !last;
                return;
            end
            acc = {bit_acc[5:0], lookup[5:0]};
            cnt = int'(bit_cnt) + 6;
            if (cnt >= 8) begin
                cnt -= 8;
                outs[n] = data_result(8'(acc >> cnt));
                n++;
                acc = acc & ((12'd1 << cnt) - 12'd1);
            end
            bit_acc = acc;
            bit_cnt = 3'(cnt);
        end
        // The message end marks the final output, or a bare end marker in decode.
        if (last) begin
            if (n == 0) begin
                outs[0] = '0;
                n = 1;
            end
            outs[n - 1].end_of_message = 1'b1;
            bit_acc = '0;
            bit_cnt = '0;
        end
        for (int i = 0; i < n; i++) begin
            awaited_outputs.push_back(outs[i]);
        end
    endtask

    // Sends one request, idling first at random, and predicts it once accepted.
    task automatic send_item(input logic [7:0] c, input logic last);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do begin
                @(posedge aclk);
            end while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        codec_step(c, last);
    endtask

    task automatic send_message(input logic [7:0] msg[$]);
        foreach (msg[i]) begin
            send_item(msg[i], i == msg.size() - 1);
        end
    endtask

    // Stops sending until every predicted output has arrived, then lets the codec settle.
    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_outputs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_mode(input logic m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        codec_mode    = m;
        bit_acc       = '0;
        bit_cnt       = '0;
        dropping_rest = 1'b0;
    endtask

    // Encode straight after reset: one, two and three byte messages cover all padding.
    task automatic test_encode_after_reset();
        logic [7:0] msg[$];
        msg = '{8'h00};
        send_message(msg);
        msg = '{8'hFF, 8'hFF};
        send_message(msg);
        msg = '{8'h4D, 8'h61, 8'h6E};
        send_message(msg);
    endtask

    // Decode: whitespace, padding, a quiet end, a bad character and leftover bits.
    task automatic test_decode_directed();
        logic [7:0] msg[$];
        wait_for_idle();
        write_mode(MODE_DECODE);
        msg = '{"T", "W", TAB_CHAR, SPACE_CHAR, "F", "u", PAD_CHAR};
        send_message(msg);
        msg = '{"Q", 8'h80, "A", "B"};
        send_message(msg);
        msg = '{"/", LF_CHAR, VT_CHAR, "9", FF_CHAR, CR_CHAR, "+"};
        send_message(msg);
        msg = '{8'hFF};
        send_message(msg);
    endtask

    // A mode write in the middle of a message abandons it without output.
    task automatic test_mode_write_abandons();
        send_item("Q", 1'b0);
        send_item("k", 1'b0);
        wait_for_idle();
        write_mode(MODE_ENCODE);
        send_item("A", 1'b1);
    endtask

    task automatic send_encode_message();
        logic [7:0] msg[$];
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        repeat (len) msg.push_back(8'($urandom_range(0, 255)));
        send_message(msg);
    endtask

    // Valid Base64 text with random content, optional padding and scattered blanks.
    task automatic send_wellformed_text();
        logic [7:0] msg[$];
        int chars;
        int tail;
        tail  = $urandom_range(0, 2);
        chars = 4 * $urandom_range(1, 4) - tail;
        for (int i = 0; i < chars; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                msg.push_back(random_blank());
            end
            msg.push_back(char_of_sextet(6'($urandom_range(0, 63))));
        end
        if ($urandom_range(0, 1) == 1) begin
            repeat (tail) msg.push_back(PAD_CHAR);
        end
        if ($urandom_range(0, 6) == 0) begin
            msg.push_back(random_blank());
        end
        send_message(msg);
    endtask

    // Random bytes mixed with alphabet characters; most of these hit a bad character.
    task automatic send_noise_message();
        logic [7:0] msg[$];
        int len;
        len = $urandom_range(1, 8);
        repeat (len) begin
            if ($urandom_range(0, 1) == 1) begin
                msg.push_back(8'($urandom_range(0, 255)));
            end else begin
                msg.push_back(char_of_sextet(6'($urandom_range(0, 63))));
            end
        end
        send_message(msg);
    endtask

    // Random messages in both modes under one pair of idle rates.
    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int first;
        wait_for_idle();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_mode(MODE_ENCODE);
        first = useful_items;
        while (useful_items - first < ITEMS_PER_MODE) begin
            send_encode_message();
        end
        wait_for_idle();
        write_mode(MODE_DECODE);
        first = useful_items;
        while (useful_items - first < ITEMS_PER_MODE) begin
            if ($urandom_range(0, 3) == 0) begin
                send_noise_message();
            end else begin
                send_wellformed_text();
            end
        end
    endtask

    // Receiver back-pressure.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Compare each accepted output request with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_output = {m_tuser[1], m_tlast, m_tuser[0], m_tdata};
            if (awaited_outputs.size() == 0) begin
                if (fail_count < REPORT_LIMIT) begin
                    $display("%0t: unexpected output: expected none, actual byte=%02h ",
                             $time, seen_output.out_byte,
                             "has_data=%b eom=%b bad_char=%b", seen_output.has_data,
                             seen_output.end_of_message, seen_output.bad_char);
                end
                fail_count++;
            end else begin
                wanted_output = awaited_outputs.pop_front();
                if (seen_output !== wanted_output) begin
                    if (fail_count < REPORT_LIMIT) begin
                        $display("%0t: output mismatch: expected byte=%02h has_data=%b ",
                                 $time, wanted_output.out_byte, wanted_output.has_data,
                                 "eom=%b bad_char=%b, actual byte=%02h has_data=%b ",
                                 wanted_output.end_of_message, wanted_output.bad_char,
                                 seen_output.out_byte, seen_output.has_data,
                                 "eom=%b bad_char=%b", seen_output.end_of_message,
                                 seen_output.bad_char);
                    end
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        m_tready      = 1'b0;
        codec_mode    = MODE_ENCODE;
        bit_acc       = '0;
        bit_cnt       = '0;
        dropping_rest = 1'b0;
        useful_items  = 0;
        fail_count    = 0;
        cycle_count   = 0;
        send_idle_pct = 28;
        recv_idle_pct = 88;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_encode_after_reset();
        test_decode_directed();
        test_mode_write_abandons();
        test_random_traffic(28, 88);
        test_random_traffic(88, 28);
        test_random_traffic(0, 0);
        wait_for_idle();

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
